### rtl/ces_pkg.sv
package ces_pkg;

   // Parser phase: idle, after the caret, after the x, then after one to five hex digits.
   typedef enum logic [2:0] {
      PH_IDLE  = 3'd0,
      PH_CARET = 3'd1,
      PH_X     = 3'd2,
      PH_D1    = 3'd3,
      PH_D2    = 3'd4,
      PH_D3    = 3'd5,
      PH_D4    = 3'd6,
      PH_D5    = 3'd7
   } phase_type;

   // One result as it leaves the parser.
   typedef struct packed {
      logic       found;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } result_type;

   // Decoded hex digit.
   typedef struct packed {
      logic       ok;
      logic [3:0] value;
   } nibble_type;

   localparam logic [7:0] CHAR_CARET   = 8'h5E;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_F = 8'h46;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_F = 8'h66;
   localparam logic [7:0] CHAR_UPPER_X = 8'h58;
   localparam logic [7:0] CHAR_LOWER_X = 8'h78;

   // Palette levels: 1.0, 0.7 and 0.4 scaled to 255 and truncated.
   localparam logic [7:0] LEVEL_FULL = 8'd255;
   localparam logic [7:0] LEVEL_HIGH = 8'd178;
   localparam logic [7:0] LEVEL_LOW  = 8'd102;
   localparam logic [7:0] LEVEL_NONE = 8'd0;

   // Returns the color of a palette entry as red, green, blue.
   function automatic logic [23:0] palette_color(input logic [3:0] index);
      logic [23:0] color;
      begin
         case (index)
            4'd0:    color = {LEVEL_NONE, LEVEL_NONE, LEVEL_NONE};
            4'd1:    color = {LEVEL_FULL, LEVEL_NONE, LEVEL_NONE};
            4'd2:    color = {LEVEL_NONE, LEVEL_FULL, LEVEL_NONE};
            4'd3:    color = {LEVEL_NONE, LEVEL_NONE, LEVEL_FULL};
            4'd4:    color = {LEVEL_FULL, LEVEL_FULL, LEVEL_NONE};
            4'd5:    color = {LEVEL_FULL, LEVEL_NONE, LEVEL_FULL};
            4'd6:    color = {LEVEL_NONE, LEVEL_FULL, LEVEL_FULL};
            4'd7:    color = {LEVEL_FULL, LEVEL_FULL, LEVEL_FULL};
            4'd8:    color = {LEVEL_HIGH, LEVEL_HIGH, LEVEL_HIGH};
            4'd9:    color = {LEVEL_LOW, LEVEL_LOW, LEVEL_LOW};
            default: color = {LEVEL_NONE, LEVEL_NONE, LEVEL_NONE};
         endcase
         return color;
      end
   endfunction

   // Decodes a hex digit in either case. Letters A to F have low nibbles 1 to 6.
   function automatic nibble_type nibble_decode(input logic [7:0] ch);
      nibble_type nib;
      begin
         nib.ok    = 1'b0;
         nib.value = 4'd0;
         if (ch inside {[CHAR_ZERO:CHAR_NINE]}) begin
            nib.ok    = 1'b1;
            nib.value = ch[3:0];
         end else if (ch inside {[CHAR_UPPER_A:CHAR_UPPER_F], [CHAR_LOWER_A:CHAR_LOWER_F]}) begin
            nib.ok    = 1'b1;
            nib.value = ch[3:0] + 4'd9;
         end
         return nib;
      end
   endfunction

endpackage

### rtl/ces_parser.sv
module ces_parser (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic [7:0]            char_code,
   input  logic                  end_of_text,
   output ces_pkg::result_type   result
);

   ces_pkg::phase_type  phase_ff, phase_in;
   logic [19:0]         accum_ff, accum_in;
   logic                have_ff, have_in;
   logic [23:0]         color_ff, color_in;
   ces_pkg::nibble_type nib;

   assign nib = ces_pkg::nibble_decode(char_code);

   // Next parser state for the character in the input register.
   always_comb begin
      phase_in = ces_pkg::PH_IDLE;
      accum_in = accum_ff;
      have_in  = have_ff;
      color_in = color_ff;
      if (char_code == ces_pkg::CHAR_CARET) begin
         phase_in = ces_pkg::PH_CARET;
      end else begin
         case (phase_ff)
            ces_pkg::PH_CARET: begin
               if (char_code inside {[ces_pkg::CHAR_ZERO:ces_pkg::CHAR_NINE]}) begin
                  color_in = ces_pkg::palette_color(char_code[3:0]);
                  have_in  = 1'b1;
               end else if (char_code == ces_pkg::CHAR_UPPER_X ||
                            char_code == ces_pkg::CHAR_LOWER_X) begin
                  phase_in = ces_pkg::PH_X;
                  accum_in = '0;
               end
            end
            ces_pkg::PH_X, ces_pkg::PH_D1, ces_pkg::PH_D2,
            ces_pkg::PH_D3, ces_pkg::PH_D4: begin
               if (nib.ok) begin
                  accum_in = {accum_ff[15:0], nib.value};
                  phase_in = ces_pkg::phase_type'(phase_ff + 3'd1);
               end
            end
            ces_pkg::PH_D5: begin
               // The sixth digit completes the RGB escape.
               if (nib.ok) begin
                  color_in = {accum_ff, nib.value};
                  have_in  = 1'b1;
               end
            end
            default: begin
               phase_in = ces_pkg::PH_IDLE;
            end
         endcase
      end
   end

   // The result reflects the text including the current character.
   assign result.found = have_in;
   assign result.red   = color_in[23:16];
   assign result.green = color_in[15:8];
   assign result.blue  = color_in[7:0];

   // State registers; the end of a text returns everything to idle.
   always_ff @(posedge clock) begin
      if (reset || (step && end_of_text)) begin
         phase_ff <= ces_pkg::PH_IDLE;
         accum_ff <= '0;
         have_ff  <= 1'b0;
         color_ff <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         accum_ff <= accum_in;
         have_ff  <= have_in;
         color_ff <= color_in;
      end
   end

endmodule

### rtl/color_escape_scanner.sv
// A result reaches rsp_tvalid through the input register and then the result register once the
// transaction that carries the last character of a text is accepted.
// Throughput: one character per cycle, set by the single input register stage.
// Stalls on the result side hold the input only when a result is still pending.
// Reset is synchronous and returns the parser to idle with no color seen.
module color_escape_scanner (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_code
   input  logic        req_tlast,   // end_of_text
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] red, [15:8] green, [23:16] blue
   output logic        rsp_tuser    // [0] found
);

   logic                s1_valid_ff, s1_valid_in;
   logic [7:0]          s1_char_ff;
   logic                s1_last_ff;
   logic                s1_advance;
   logic                rsp_load;
   logic                rsp_valid_ff, rsp_valid_in;
   ces_pkg::result_type rsp_data_ff;
   ces_pkg::result_type result;

   // The input stage moves on unless it holds a last character while a result waits.
   assign s1_advance = s1_valid_ff && (!s1_last_ff || !rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_advance;
   assign rsp_load   = s1_advance && s1_last_ff;

   // Input register.
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_tready) begin
         s1_valid_in = req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         s1_char_ff <= req_tdata;
         s1_last_ff <= req_tlast;
      end
   end

   ces_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .step        (s1_advance),
      .char_code   (s1_char_ff),
      .end_of_text (s1_last_ff),
      .result      (result)
   );

   // Result register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_data_ff.blue, rsp_data_ff.green, rsp_data_ff.red};
   assign rsp_tuser  = rsp_data_ff.found;

endmodule

### rtl/ces_checker.sv
module ces_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tlast,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic        rsp_tuser
);

   // A stalled result transaction holds its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
   else $error("result changed while stalled");

   // A text without a complete escape reports black.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == 24'd0)
   else $error("color reported without an escape");

   // Reset leaves no result pending.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
   else $error("result pending after reset");

   // A text of one character that follows reset cannot contain a complete escape.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast && $past(reset) |=> ##1
         (rsp_tvalid && !rsp_tuser))
   else $error("single character text reported a color");

endmodule

bind color_escape_scanner ces_checker u_ces_checker (.*);
